[hdl/priority_threshold_view_selector_assert.svh]
// Assertion macros used by the selector top level.
`ifndef PRIORITY_THRESHOLD_VIEW_SELECTOR_ASSERT_SVH
`define PRIORITY_THRESHOLD_VIEW_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTVS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("selector check failed");

// Next-cycle implication, checked outside reset.
`define PTVS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("selector check failed");

`endif

[hdl/ptvs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ptvs_pkg;

  // Rule word packing, MSB first.
  typedef struct packed {
    logic [3:0]  view;
    logic        enable;
    logic [1:0]  prio;
    logic [2:0]  mode;
    logic [31:0] threshold;
  } rule_t;

  localparam int RULE_W   = $bits(rule_t);
  localparam int REG_COUNT = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [2:0] CMP_LT = 3'd0;
  localparam logic [2:0] CMP_LE = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_GE = 3'd3;
  localparam logic [2:0] CMP_EQ = 3'd4;
  localparam logic [2:0] CMP_NE = 3'd5;

  localparam logic [1:0] PRIO_DEFAULT = 2'd0;

  localparam logic [1:0] DEC_RULE    = 2'd0;
  localparam logic [1:0] DEC_DEFAULT = 2'd1;
  localparam logic [1:0] DEC_KEPT    = 2'd2;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic cmp_holds(input logic [31:0] value, input logic [31:0] thr,
                                     input logic [2:0] mode);
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               r;
    a = $signed(value);
    b = $signed(thr);
    unique case (mode)
      CMP_LT:  r = (a < b);
      CMP_LE:  r = (a <= b);
      CMP_GT:  r = (a > b);
      CMP_GE:  r = (a >= b);
      CMP_EQ:  r = (a == b);
      CMP_NE:  r = (a != b);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/ptvs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ptvs_front #(
  parameter int SLOT_COUNT = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ptvs_pkg::rule_t  rules [SLOT_COUNT],
  input  wire logic             in_valid,
  input  wire logic [1:0]       slot,
  input  wire logic [31:0]      sample,
  input  wire logic             q_full,
  output logic                  push,
  output logic [SLOT_COUNT-1:0] hit
);
  import ptvs_pkg::*;

  logic [31:0]           slot_values      [SLOT_COUNT];
  logic [31:0]           slot_values_next [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] value_seen;
  logic [SLOT_COUNT-1:0] value_seen_next;

  assign push = in_valid && !q_full;

  // Compare against the value this item leaves behind.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (int'(slot) == i) begin
        slot_values_next[i] = sample;
        value_seen_next[i]  = 1'b1;
      end else begin
        slot_values_next[i] = slot_values[i];
        value_seen_next[i]  = value_seen[i];
      end
      hit[i] = rules[i].enable && value_seen_next[i] && (rules[i].prio != PRIO_DEFAULT) &&
               cmp_holds(slot_values_next[i], rules[i].threshold, rules[i].mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_seen <= '0;
    end else if (push) begin
      value_seen <= value_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_values[i] <= slot_values_next[i];
      end
    end
  end

endmodule
`default_nettype wire

[hdl/ptvs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module ptvs_queue #(
  parameter int WIDTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output ptvs_pkg::qstat_t      stat
);
  import ptvs_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[hdl/ptvs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module ptvs_back #(
  parameter int SLOT_COUNT = 4,
  parameter int VIEW_COUNT = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ptvs_pkg::rule_t       rules [SLOT_COUNT],
  input  wire logic [SLOT_COUNT-1:0] hit,
  input  wire ptvs_pkg::qstat_t      qstat,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 view_index,
  output logic [1:0]                 winning_slot,
  output logic [1:0]                 decided_by
);
  import ptvs_pkg::*;

  logic [3:0] current_view;
  logic [3:0] sel_view;
  logic [1:0] sel_slot;
  logic [1:0] sel_how;
  logic       found;

  // Saturate a rule's view to the last legal view.
  function automatic logic [3:0] sat_view(input logic [3:0] v);
    return ({1'b0, v} >= 5'(VIEW_COUNT)) ? 4'(VIEW_COUNT - 1) : v;
  endfunction

  assign pop = !qstat.empty && (!out_valid || !out_stall);

  // Scan levels high to low, lowest slot first; then the first default rule; else keep the view.
  always_comb begin
    found    = 1'b0;
    sel_view = current_view;
    sel_slot = '0;
    sel_how  = DEC_KEPT;
    for (int lvl = 3; lvl > 0; lvl--) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!found && hit[i] && (rules[i].prio == 2'(lvl))) begin
          found    = 1'b1;
          sel_view = sat_view(rules[i].view);
          sel_slot = 2'(i);
          sel_how  = DEC_RULE;
        end
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!found && (rules[i].prio == PRIO_DEFAULT)) begin
        found    = 1'b1;
        sel_view = sat_view(rules[i].view);
        sel_slot = 2'(i);
        sel_how  = DEC_DEFAULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      current_view <= '0;
    end else begin
      if (pop) begin
        out_valid    <= 1'b1;
        current_view <= sel_view;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      view_index   <= sel_view;
      winning_slot <= sel_slot;
      decided_by   <= sel_how;
    end
  end

endmodule
`default_nettype wire

[hdl/priority_threshold_view_selector.sv]
// Priority threshold view selector.
// Input channel (in_valid / in_stall): each item carries a slot number and a
// signed Q16.16 sample that replaces that slot's stored sensor value.
// Output channel (out_valid / out_stall): one item per input item, giving the
// chosen view, the slot whose rule decided it and how it was decided.
// Rule words are written through wr_en / wr_index / wr_data while idle; the
// user must keep to that, as the block itself does not enforce it.
// An item taken at a clock edge is pushed into the queue and then moved into
// the output register; one item per cycle is sustained while out_stall is
// low, given by the compare stage, the two-entry queue and the select stage.
// When the receiver stalls, the result is held in the output register and
// the queue absorbs up to two more items before in_stall rises.
// Reset (rst, synchronous) clears the rules, the seen flags, the queue and
// the current view; the output goes invalid.
`timescale 1ns / 1ps
`default_nettype none
module priority_threshold_view_selector #(
  parameter int SLOT_COUNT = 4,
  parameter int VIEW_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [41:0] wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  slot,
  input  wire logic [31:0] sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       view_index,
  output logic [1:0]       winning_slot,
  output logic [1:0]       decided_by
);
  import ptvs_pkg::*;

  `include "priority_threshold_view_selector_assert.svh"

  rule_t                 rules [SLOT_COUNT];
  logic                  push;
  logic                  pop;
  logic [SLOT_COUNT-1:0] hit_in;
  logic [SLOT_COUNT-1:0] hit_out;
  qstat_t                qstat;

  // Writes past the implemented slots are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        rules[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if ((int'(wr_index) == i) && (i < REG_COUNT)) begin
          rules[i] <= rule_t'(wr_data);
        end
      end
    end
  end

  assign in_stall = qstat.full;

  ptvs_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rules    (rules),
    .in_valid (in_valid),
    .slot     (slot),
    .sample   (sample),
    .q_full   (qstat.full),
    .push     (push),
    .hit      (hit_in)
  );

  ptvs_queue #(
    .WIDTH(SLOT_COUNT)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (hit_in),
    .pop   (pop),
    .rdata (hit_out),
    .stat  (qstat)
  );

  ptvs_back #(
    .SLOT_COUNT(SLOT_COUNT),
    .VIEW_COUNT(VIEW_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .rules        (rules),
    .hit          (hit_out),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .view_index   (view_index),
    .winning_slot (winning_slot),
    .decided_by   (decided_by)
  );

  `PTVS_ASSERT_NOW(a_kept_slot_zero, out_valid && (decided_by == DEC_KEPT), winning_slot == '0)
  `PTVS_ASSERT_NOW(a_decided_legal, out_valid,
                   (decided_by == DEC_RULE) || (decided_by == DEC_DEFAULT) ||
                   (decided_by == DEC_KEPT))
  `PTVS_ASSERT_NEXT(a_item_held, in_valid && !in_stall, !qstat.empty || out_valid)
  `PTVS_ASSERT_NOW(a_queue_sane, 1'b1, !(qstat.full && qstat.empty))

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import ptvs_pkg::*;

  localparam int         CYCLE_LIMIT  = 300000;
  localparam int         SEGMENTS     = 20;
  localparam int         SEGMENT_LEN  = 50;
  localparam logic [1:0] PRIO_TOP     = 2'd3;
  localparam logic [2:0] CMP_NEVER6   = 3'd6;
  localparam logic [2:0] CMP_NEVER7   = 3'd7;
  localparam logic [31:0] Q_MIN       = 32'h8000_0000;
  localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;

  typedef struct {
    logic [3:0] view;
    logic [1:0] slot;
    logic [1:0] how;
  } view_choice_t;

  class view_scoreboard;
    rule_t        rules [REG_COUNT];
    logic [31:0]  slot_value [REG_COUNT];
    bit           seen [REG_COUNT];
    logic [3:0]   shown_view;
    view_choice_t choices [$];
    int           errors;
    int           items_noted;
    int           results_checked;
    int           by_rule;
    int           by_default;
    int           kept;

    function new();
      for (int i = 0; i < REG_COUNT; i++) begin
        rules[i] = '0;
        slot_value[i] = '0;
        seen[i] = 1'b0;
      end
      shown_view = '0;
      errors = 0;
      items_noted = 0;
      results_checked = 0;
      by_rule = 0;
      by_default = 0;
      kept = 0;
    endfunction

    function void set_rule(int idx, rule_t r);
      rules[idx] = r;
    endfunction

    function void note_item(logic [1:0] s, logic [31:0] v);
      view_choice_t       c;
      logic signed [31:0] a;
      logic signed [31:0] b;
      bit                 hit;
      bit                 found;
      slot_value[s] = v;
      seen[s] = 1'b1;
      c.view = shown_view;
      c.slot = '0;
      c.how = DEC_KEPT;
      found = 1'b0;
      for (int lvl = PRIO_TOP; lvl > 0 && !found; lvl--) begin
        for (int i = 0; i < REG_COUNT && !found; i++) begin
          if (rules[i].prio != lvl || !rules[i].enable || !seen[i]) continue;
          a = $signed(slot_value[i]);
          b = $signed(rules[i].threshold);
          case (rules[i].mode)
            CMP_LT:  hit = (a < b);
            CMP_LE:  hit = (a <= b);
            CMP_GT:  hit = (a > b);
            CMP_GE:  hit = (a >= b);
            CMP_EQ:  hit = (a == b);
            CMP_NE:  hit = (a != b);
            default: hit = 1'b0;
          endcase
          if (hit) begin
            found = 1'b1;
            c.view = rules[i].view;
            c.slot = i[1:0];
            c.how = DEC_RULE;
          end
        end
      end
      // fall back to the lowest default rule; its enable and value do not matter
      for (int i = 0; i < REG_COUNT && !found; i++) begin
        if (rules[i].prio == PRIO_DEFAULT) begin
          found = 1'b1;
          c.view = rules[i].view;
          c.slot = i[1:0];
          c.how = DEC_DEFAULT;
        end
      end
      shown_view = c.view;
      choices.push_back(c);
      items_noted++;
    endfunction

    function void check_result(logic [3:0] view, logic [1:0] s, logic [1:0] how);
      view_choice_t c;
      if (choices.size() == 0) begin
        $display("%0t: result with nothing expected: view %0d, slot %0d, decided_by %0d",
                 $time, view, s, how);
        errors++;
        return;
      end
      c = choices.pop_front();
      results_checked++;
      case (c.how)
        DEC_RULE:    by_rule++;
        DEC_DEFAULT: by_default++;
        default:     kept++;
      endcase
      if (view !== c.view) begin
        $display("%0t: view_index expected %0d, actual %0d", $time, c.view, view);
        errors++;
      end
      if (s !== c.slot) begin
        $display("%0t: winning_slot expected %0d, actual %0d", $time, c.slot, s);
        errors++;
      end
      if (how !== c.how) begin
        $display("%0t: decided_by expected %0d, actual %0d", $time, c.how, how);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [RULE_W-1:0]    wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           slot = '0;
  logic [31:0]          sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [3:0]           view_index;
  logic [1:0]           winning_slot;
  logic [1:0]           decided_by;

  view_scoreboard sb;
  rule_t          rule_plan [REG_COUNT];
  logic [31:0]    value_pool [4];
  bit             in_quiet = 1'b0;
  bit             out_quiet = 1'b0;
  int             cycle_count = 0;

  priority_threshold_view_selector DUT (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .slot         (slot),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .view_index   (view_index),
    .winning_slot (winning_slot),
    .decided_by   (decided_by)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_stall === 1'b0)
      sb.note_item(slot, sample);
    if (!rst && out_valid === 1'b1 && !out_stall)
      sb.check_result(view_index, winning_slot, decided_by);
  end

  // receiver: hold off for a drawn number of cycles, then take one item
  initial begin : result_taker
    int hold;
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic rule_t make_rule(input logic [3:0] v, input logic en,
                                      input logic [1:0] p, input logic [2:0] m,
                                      input logic [31:0] thr);
    return '{view: v, enable: en, prio: p, mode: m, threshold: thr};
  endfunction

  function automatic rule_t random_rule();
    rule_t r;
    r.view = 4'($urandom_range(0, 15));
    r.enable = ($urandom_range(0, 4) != 0);
    r.prio = 2'($urandom_range(0, 3));
    r.mode = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5));
    r.threshold = ($urandom_range(0, 4) == 0) ? $urandom() : value_pool[$urandom_range(0, 3)];
    return r;
  endfunction

  // samples cluster around the thresholds so comparisons land on both sides
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 6))
      0:       return $urandom();
      1:       return value_pool[$urandom_range(0, 3)] + 32'd1;
      2:       return value_pool[$urandom_range(0, 3)] - 32'd1;
      3:       return $urandom_range(0, 1) ? Q_MIN : Q_MAX;
      default: return value_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  task automatic apply_rules();
    for (int i = 0; i < REG_COUNT; i++) begin
      wr_en <= 1'b1;
      wr_index <= REG_IDX_W'(i);
      wr_data <= rule_plan[i];
      sb.set_rule(i, rule_plan[i]);
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] s, input logic [31:0] v);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    slot <= s;
    sample <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.choices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int kind;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero rules after reset: slot 0 acts as default with view 0
    send_item(2'd0, Q_MIN);
    send_item(2'd3, Q_MAX);
    settle();

    // slots 1 and 2 not yet seen must be skipped
    rule_plan[0] = make_rule(4'd8, 1'b1, 2'd1, CMP_NEVER6, 32'd0);
    rule_plan[1] = make_rule(4'd10, 1'b1, 2'd3, CMP_GE, Q_MIN);
    rule_plan[2] = make_rule(4'd11, 1'b1, 2'd3, CMP_GE, Q_MIN);
    rule_plan[3] = make_rule(4'd9, 1'b0, PRIO_DEFAULT, CMP_LT, 32'd0);
    apply_rules();
    send_item(2'd0, 32'd5);
    send_item(2'd2, 32'hFFFF_FFFF);
    send_item(2'd1, Q_MAX);
    settle();

    // ordered comparisons at the range limits, no default rule
    rule_plan[0] = make_rule(4'd15, 1'b1, 2'd3, CMP_GT, Q_MAX);
    rule_plan[1] = make_rule(4'd1, 1'b1, 2'd2, CMP_LE, 32'd0);
    rule_plan[2] = make_rule(4'd2, 1'b1, 2'd2, CMP_LT, Q_MIN);
    rule_plan[3] = make_rule(4'd3, 1'b1, 2'd1, CMP_GE, Q_MAX);
    apply_rules();
    send_item(2'd1, 32'd0);
    send_item(2'd1, 32'd1);
    send_item(2'd3, 32'h7FFF_FFFE);
    send_item(2'd0, Q_MAX);
    send_item(2'd2, Q_MIN);
    settle();

    // equality and the two invalid modes
    rule_plan[0] = make_rule(4'd4, 1'b1, 2'd1, CMP_EQ, Q_MIN);
    rule_plan[1] = make_rule(4'd5, 1'b1, 2'd1, CMP_NE, 32'd0);
    rule_plan[2] = make_rule(4'd6, 1'b1, 2'd1, CMP_NEVER6, 32'd0);
    rule_plan[3] = make_rule(4'd7, 1'b1, 2'd1, CMP_NEVER7, 32'd0);
    apply_rules();
    send_item(2'd1, 32'd0);
    send_item(2'd0, Q_MIN);
    send_item(2'd0, 32'd0);
    send_item(2'd3, 32'd0);
    settle();

    // all ones everywhere: invalid mode on every slot, view kept
    for (int i = 0; i < REG_COUNT; i++) rule_plan[i] = '1;
    apply_rules();
    send_item(2'd2, 32'hFFFF_FFFF);
    send_item(2'd3, 32'h0001_0000);
    settle();

    // a disabled rule that would match, default on slot 1
    rule_plan[0] = make_rule(4'd12, 1'b0, 2'd3, CMP_NE, 32'd0);
    rule_plan[1] = make_rule(4'd15, 1'b1, PRIO_DEFAULT, CMP_EQ, Q_MAX);
    rule_plan[2] = make_rule(4'd0, 1'b0, 2'd2, CMP_LT, 32'd0);
    rule_plan[3] = make_rule(4'd0, 1'b0, 2'd1, CMP_GT, 32'd0);
    apply_rules();
    send_item(2'd0, 32'd1);
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      for (int i = 0; i < 4; i++)
        value_pool[i] = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 16) - 32'd8;
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < REG_COUNT; i++)
        rule_plan[i] = (kind == 0) ? rule_t'('0) : (kind == 1) ? rule_t'('1) : random_rule();
      apply_rules();
      for (int n = 0; n < SEGMENT_LEN; n++)
        send_item(2'($urandom_range(0, 3)), pick_sample());
      settle();
    end

    $display("Sent %0d sensor updates over %0d rule settings; %0d views checked.",
             sb.items_noted, SEGMENTS + 6, sb.results_checked);
    $display("Decisions: %0d by rule match, %0d by default rule, %0d view kept.",
             sb.by_rule, sb.by_default, sb.kept);
    if (sb.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ptvs_pkg.sv
hdl/ptvs_front.sv
hdl/ptvs_queue.sv
hdl/ptvs_back.sv
hdl/priority_threshold_view_selector.sv
sim/testbench.sv
